### rtl/ratgcd_pkg.sv
// Shared types, constants and the microcode program for the rational arithmetic core.
// Depends on nothing; every other file in this folder imports it.

package ratgcd_pkg;

    localparam int IN_W   = 32;          // width of an operand port
    localparam int OPD_W  = IN_W + 1;    // operand after sign extension, room for negation
    localparam int PROD_W = 2 * OPD_W;   // full product of two operands
    localparam int MAG_W  = 64;          // result words and magnitudes
    localparam int K_W    = 6;           // count of common factors of two
    localparam int CNT_W  = 6;           // bit counter of the divider, one step per quotient bit
    localparam int PC_W   = 5;           // microprogram counter

    typedef logic [1:0]      t_cmd;
    typedef logic [4:0]      t_op;
    typedef logic [3:0]      t_cond;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_cmd CMD_ADD = 2'd0;
    localparam t_cmd CMD_SUB = 2'd1;
    localparam t_cmd CMD_MUL = 2'd2;
    localparam t_cmd CMD_DIV = 2'd3;

    // Datapath operations, one per control word.
    localparam t_op OP_LOAD    = 5'd0;
    localparam t_op OP_NOP     = 5'd1;
    localparam t_op OP_MUL_LHS = 5'd2;
    localparam t_op OP_MUL_RHS = 5'd3;
    localparam t_op OP_CMP     = 5'd4;
    localparam t_op OP_MUL_T1  = 5'd5;
    localparam t_op OP_MUL_T2  = 5'd6;
    localparam t_op OP_SUM     = 5'd7;
    localparam t_op OP_MAG     = 5'd8;
    localparam t_op OP_TWOS    = 5'd9;
    localparam t_op OP_GCD     = 5'd10;
    localparam t_op OP_DSET    = 5'd11;
    localparam t_op OP_DIV     = 5'd12;
    localparam t_op OP_RES     = 5'd13;
    localparam t_op OP_ZERO    = 5'd14;
    localparam t_op OP_ERR     = 5'd15;
    localparam t_op OP_OUT     = 5'd16;

    // Jump conditions. A taken jump loads the target, otherwise the counter steps by one.
    localparam t_cond C_NEVER     = 4'd0;
    localparam t_cond C_ALWAYS    = 4'd1;
    localparam t_cond C_NO_START  = 4'd2;
    localparam t_cond C_DEN_ZERO  = 4'd3;
    localparam t_cond C_XD_ZERO   = 4'd4;
    localparam t_cond C_NUM_ZERO  = 4'd5;
    localparam t_cond C_BOTH_EVEN = 4'd6;
    localparam t_cond C_GCD_BUSY  = 4'd7;
    localparam t_cond C_DIV_MORE  = 4'd8;
    localparam t_cond C_OUT_BUSY  = 4'd9;

    // Program addresses.
    localparam t_pc P_IDLE = 5'd0;
    localparam t_pc P_LHS  = 5'd1;
    localparam t_pc P_RHS  = 5'd2;
    localparam t_pc P_CMP  = 5'd3;
    localparam t_pc P_T1   = 5'd4;
    localparam t_pc P_T2   = 5'd5;
    localparam t_pc P_SUM  = 5'd6;
    localparam t_pc P_MAG  = 5'd7;
    localparam t_pc P_ZCHK = 5'd8;
    localparam t_pc P_TWOS = 5'd9;
    localparam t_pc P_GCD  = 5'd10;
    localparam t_pc P_DSET = 5'd11;
    localparam t_pc P_DIV  = 5'd12;
    localparam t_pc P_RES  = 5'd13;
    localparam t_pc P_ZERO = 5'd14;
    localparam t_pc P_ERR  = 5'd15;
    localparam t_pc P_OUT  = 5'd16;
    localparam t_pc P_END  = 5'd17;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic den_zero;
        logic xd_zero;
        logic num_zero;
        logic both_even;
        logic gcd_busy;
        logic div_more;
    } t_dp_stat;

    typedef struct packed {
        logic signed [MAG_W-1:0] num;
        logic signed [MAG_W-1:0] den;
        logic                    less;
        logic                    equal;
        logic                    error;
    } t_result;

    // The microprogram.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            P_IDLE:  w = '{OP_LOAD,    C_NO_START,  P_IDLE};
            P_LHS:   w = '{OP_MUL_LHS, C_DEN_ZERO,  P_ERR};
            P_RHS:   w = '{OP_MUL_RHS, C_NEVER,     P_IDLE};
            P_CMP:   w = '{OP_CMP,     C_XD_ZERO,   P_ERR};
            P_T1:    w = '{OP_MUL_T1,  C_NEVER,     P_IDLE};
            P_T2:    w = '{OP_MUL_T2,  C_NEVER,     P_IDLE};
            P_SUM:   w = '{OP_SUM,     C_NEVER,     P_IDLE};
            P_MAG:   w = '{OP_MAG,     C_NEVER,     P_IDLE};
            P_ZCHK:  w = '{OP_NOP,     C_NUM_ZERO,  P_ZERO};
            P_TWOS:  w = '{OP_TWOS,    C_BOTH_EVEN, P_TWOS};
            P_GCD:   w = '{OP_GCD,     C_GCD_BUSY,  P_GCD};
            P_DSET:  w = '{OP_DSET,    C_NEVER,     P_IDLE};
            P_DIV:   w = '{OP_DIV,     C_DIV_MORE,  P_DIV};
            P_RES:   w = '{OP_RES,     C_ALWAYS,    P_OUT};
            P_ZERO:  w = '{OP_ZERO,    C_ALWAYS,    P_OUT};
            P_ERR:   w = '{OP_ERR,     C_NEVER,     P_IDLE};
            P_OUT:   w = '{OP_OUT,     C_OUT_BUSY,  P_OUT};
            P_END:   w = '{OP_NOP,     C_ALWAYS,    P_IDLE};
            default: w = '{OP_NOP,     C_ALWAYS,    P_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/ratgcd_useq.sv
// Microprogram sequencer: program counter, control store lookup and jump conditions.
// Depends on ratgcd_pkg for the control word layout and the program.

module ratgcd_useq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_out_busy,
    input  ratgcd_pkg::t_dp_stat i_stat,
    output ratgcd_pkg::t_op      o_op
);
    import ratgcd_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;
    logic   taken;

    assign uw   = ucode(r_pc);
    assign o_op = uw.op;

    always_comb begin
        case (uw.cond)
            C_NEVER:     taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_START:  taken = !i_start;
            C_DEN_ZERO:  taken = i_stat.den_zero;
            C_XD_ZERO:   taken = i_stat.xd_zero;
            C_NUM_ZERO:  taken = i_stat.num_zero;
            C_BOTH_EVEN: taken = i_stat.both_even;
            C_GCD_BUSY:  taken = i_stat.gcd_busy;
            C_DIV_MORE:  taken = i_stat.div_more;
            C_OUT_BUSY:  taken = i_out_busy;
            default:     taken = 1'b1;
        endcase
        n_pc = taken ? uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### rtl/ratgcd_dpath.sv
// Datapath: operand registers, shared multiplier, binary GCD unit and two-lane divider.
// Depends on ratgcd_pkg; driven one operation per cycle by ratgcd_useq.

module ratgcd_dpath #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                                i_clk,
    input  ratgcd_pkg::t_op                     i_op,
    input  logic                                i_load,
    input  ratgcd_pkg::t_cmd                    i_command,
    input  logic signed [ratgcd_pkg::IN_W-1:0]  i_a_num,
    input  logic signed [ratgcd_pkg::IN_W-1:0]  i_a_den,
    input  logic signed [ratgcd_pkg::IN_W-1:0]  i_b_num,
    input  logic signed [ratgcd_pkg::IN_W-1:0]  i_b_den,
    output ratgcd_pkg::t_dp_stat                o_stat,
    output ratgcd_pkg::t_result                 o_result
);
    import ratgcd_pkg::*;

    function automatic logic signed [OPD_W-1:0] sext(input logic [IN_W-1:0] v);
        logic signed [OPD_W-1:0] s;
        for (int i = 0; i < IN_W; i++) begin
            s[i] = (i < OPERAND_WIDTH) ? v[i] : v[OPERAND_WIDTH-1];
        end
        s[OPD_W-1] = v[OPERAND_WIDTH-1];
        return s;
    endfunction

    // One restoring division step: remainder and dividend/quotient shift together.
    function automatic logic [2*MAG_W-1:0] div_step(
        input logic [MAG_W-1:0] rem,
        input logic [MAG_W-1:0] q,
        input logic [MAG_W-1:0] g
    );
        logic [MAG_W:0]   part;
        logic [MAG_W:0]   trial;
        logic [MAG_W-1:0] rem_n;
        logic             bit_n;
        part  = {rem, q[MAG_W-1]};
        trial = part - {1'b0, g};
        if (!trial[MAG_W]) begin
            rem_n = trial[MAG_W-1:0];
            bit_n = 1'b1;
        end else begin
            rem_n = part[MAG_W-1:0];
            bit_n = 1'b0;
        end
        return {rem_n, q[MAG_W-2:0], bit_n};
    endfunction

    localparam logic signed [MAG_W-1:0] POS_MAX = {1'b0, {(MAG_W-1){1'b1}}};

    t_cmd                    r_cmd;
    logic signed [OPD_W-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [MAG_W-1:0] r_lhs, r_rhs, r_d;
    logic signed [MAG_W:0]   r_sum;
    logic [MAG_W-1:0]        r_x, r_y, r_nm, r_dm, r_g;
    logic [MAG_W-1:0]        r_qn, r_qd, r_rn, r_rd;
    logic [K_W-1:0]          r_k;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_nneg, r_dneg;
    logic                    r_less, r_equal, r_err;
    logic signed [MAG_W-1:0] r_res_num, r_res_den;

    logic signed [OPD_W-1:0]  xn, xd, mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     is_addsub, flip, both_even;
    logic signed [MAG_W:0]    t1e, t2e, sum_n, neg_sum;
    logic [MAG_W-1:0]         nmag, dmag;
    logic [MAG_W:0]           diff_xy, diff_yx;
    logic [2*MAG_W-1:0]       step_n, step_d;

    assign is_addsub = (r_cmd == CMD_ADD) || (r_cmd == CMD_SUB);

    // Second operand after the command has been applied.
    always_comb begin
        xn = r_bn;
        xd = r_bd;
        if (r_cmd == CMD_SUB) begin
            xn = -r_bn;
        end
        if (r_cmd == CMD_DIV) begin
            xn = r_bd;
            xd = r_bn;
        end
    end

    always_comb begin
        case (i_op)
            OP_MUL_LHS: begin mul_a = r_an; mul_b = r_bd; end
            OP_MUL_RHS: begin mul_a = r_bn; mul_b = r_ad; end
            OP_CMP:     begin mul_a = r_ad; mul_b = xd;   end
            OP_MUL_T1:  begin mul_a = r_an; mul_b = is_addsub ? xd : xn; end
            OP_MUL_T2:  begin mul_a = xn;   mul_b = r_ad; end
            default:    begin mul_a = '0;   mul_b = '0;   end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign flip    = r_ad[OPD_W-1] ^ r_bd[OPD_W-1];
    assign t1e     = {r_lhs[MAG_W-1], r_lhs};
    assign t2e     = {r_rhs[MAG_W-1], r_rhs};
    assign sum_n   = is_addsub ? t1e + t2e : t1e;
    assign neg_sum = -r_sum;
    assign nmag    = r_sum[MAG_W] ? neg_sum[MAG_W-1:0] : r_sum[MAG_W-1:0];
    assign dmag    = r_d[MAG_W-1] ? MAG_W'(-r_d) : MAG_W'(r_d);

    assign both_even = !r_x[0] && !r_y[0];
    assign diff_xy   = {1'b0, r_x} - {1'b0, r_y};
    assign diff_yx   = {1'b0, r_y} - {1'b0, r_x};

    assign step_n = div_step(r_rn, r_qn, r_g);
    assign step_d = div_step(r_rd, r_qd, r_g);

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                if (i_load) begin
                    r_cmd   <= i_command;
                    r_an    <= sext(i_a_num);
                    r_ad    <= sext(i_a_den);
                    r_bn    <= sext(i_b_num);
                    r_bd    <= sext(i_b_den);
                    r_less  <= 1'b0;
                    r_equal <= 1'b0;
                end
            end
            OP_MUL_LHS: r_lhs <= prod[MAG_W-1:0];
            OP_MUL_RHS: r_rhs <= prod[MAG_W-1:0];
            OP_CMP: begin
                r_d     <= prod[MAG_W-1:0];
                r_equal <= (r_lhs == r_rhs);
                r_less  <= flip ? (r_lhs > r_rhs) : (r_lhs < r_rhs);
            end
            OP_MUL_T1: r_lhs <= prod[MAG_W-1:0];
            OP_MUL_T2: r_rhs <= prod[MAG_W-1:0];
            OP_SUM:    r_sum <= sum_n;
            OP_MAG: begin
                r_nneg <= r_sum[MAG_W];
                r_dneg <= r_d[MAG_W-1];
                r_x    <= nmag;
                r_nm   <= nmag;
                r_y    <= dmag;
                r_dm   <= dmag;
                r_k    <= '0;
            end
            OP_TWOS: begin
                if (both_even) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end
            end
            OP_GCD: begin
                // At least one of the pair is odd here, so halving the even one keeps the GCD.
                if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x > r_y) begin
                    r_x <= diff_xy[MAG_W:1];
                end else if (r_y > r_x) begin
                    r_y <= diff_yx[MAG_W:1];
                end
            end
            OP_DSET: begin
                r_g   <= r_x << r_k;
                r_qn  <= r_nm;
                r_qd  <= r_dm;
                r_rn  <= '0;
                r_rd  <= '0;
                r_cnt <= '0;
            end
            OP_DIV: begin
                {r_rn, r_qn} <= step_n;
                {r_rd, r_qd} <= step_d;
                r_cnt        <= r_cnt + 1'b1;
            end
            OP_RES: begin
                if (r_nneg) begin
                    r_res_num <= -r_qn;
                end else begin
                    r_res_num <= r_qn[MAG_W-1] ? POS_MAX : r_qn;
                end
                r_res_den <= r_dneg ? -r_qd : r_qd;
                r_err     <= 1'b0;
            end
            OP_ZERO: begin
                r_res_num <= '0;
                r_res_den <= r_dneg ? '1 : MAG_W'(1);
                r_err     <= 1'b0;
            end
            OP_ERR: begin
                r_res_num <= MAG_W'(1);
                r_res_den <= MAG_W'(1);
                r_err     <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_stat.den_zero  = (r_ad == '0) || (r_bd == '0);
    assign o_stat.xd_zero   = (xd == '0);
    assign o_stat.num_zero  = (r_x == '0);
    assign o_stat.both_even = both_even;
    assign o_stat.gcd_busy  = (r_x != r_y);
    assign o_stat.div_more  = (r_cnt != '1);

    assign o_result.num   = r_res_num;
    assign o_result.den   = r_res_den;
    assign o_result.less  = r_less;
    assign o_result.equal = r_equal;
    assign o_result.error = r_err;

endmodule

### rtl/rational_arith_gcd_reduce_core.sv
// Top level of the rational arithmetic core with GCD reduction and its output register.
// Depends on ratgcd_pkg, ratgcd_useq and ratgcd_dpath.

// The core takes two fractions a_num/a_den and b_num/b_den with a command (add, subtract,
// multiply, divide), returns the result reduced by the GCD of its magnitudes, and reports
// whether a is below b or equal to it by value. Numerator and denominator keep their own
// signs; a zero numerator comes back as 0 over +1 or -1. A zero denominator, given or
// produced by dividing by zero, sets the error flag and returns 1/1. One transaction is in
// work at a time: the input side is ready only while the microprogram sits in its idle
// step, and a finished result waits in the output register so the next transaction can
// start while it is still pending. The length of a normal transaction is set by the binary
// GCD loop, which sheds at least one bit of either magnitude per pass until the two are
// equal, and by the 64-step two-lane divider that follows it; error transactions and a zero
// numerator skip both. OPERAND_WIDTH (8 to 32) picks how many low bits of each operand port
// are used; they are sign-extended from the top used bit.

module rational_arith_gcd_reduce_core #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_command,
    input  logic signed [ratgcd_pkg::IN_W-1:0]  i_a_num,
    input  logic signed [ratgcd_pkg::IN_W-1:0]  i_a_den,
    input  logic signed [ratgcd_pkg::IN_W-1:0]  i_b_num,
    input  logic signed [ratgcd_pkg::IN_W-1:0]  i_b_den,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ratgcd_pkg::MAG_W-1:0] o_res_num,
    output logic signed [ratgcd_pkg::MAG_W-1:0] o_res_den,
    output logic                                o_less,
    output logic                                o_equal,
    output logic                                o_error
);
    import ratgcd_pkg::*;

    t_op      op;
    t_dp_stat dp_stat;
    t_result  dp_result;
    logic     load;
    logic     out_busy;
    logic     out_load;

    logic                    r_ovalid;
    logic signed [MAG_W-1:0] r_out_num;
    logic signed [MAG_W-1:0] r_out_den;
    logic                    r_out_less;
    logic                    r_out_equal;
    logic                    r_out_error;

    // The idle step of the program is the only one that loads operands.
    assign o_ready  = (op == OP_LOAD);
    assign load     = i_valid && o_ready;

    // The output register frees up in the same cycle its transaction is taken.
    assign out_busy = r_ovalid && !i_ready;
    assign out_load = (op == OP_OUT) && !out_busy;

    ratgcd_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid),
        .i_out_busy (out_busy),
        .i_stat     (dp_stat),
        .o_op       (op)
    );

    ratgcd_dpath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_op      (op),
        .i_load    (load),
        .i_command (i_command),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_stat    (dp_stat),
        .o_result  (dp_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_num   <= dp_result.num;
            r_out_den   <= dp_result.den;
            r_out_less  <= dp_result.less;
            r_out_equal <= dp_result.equal;
            r_out_error <= dp_result.error;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_res_num = r_out_num;
    assign o_res_den = r_out_den;
    assign o_less    = r_out_less;
    assign o_equal   = r_out_equal;
    assign o_error   = r_out_error;

    // An accepted transaction moves the program out of its idle step.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input still ready after a transaction was accepted");

    // The result step waits while the output register holds an untaken result.
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_OUT && r_ovalid && !i_ready) |=> (op == OP_OUT))
        else $error("sequencer left the result step while the output was stalled");

    // An error result is always 1/1.
    a_err_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_res_num == MAG_W'(1) && o_res_den == MAG_W'(1)))
        else $error("error result is not 1/1");

    // A result without error never has a zero denominator, and less and equal exclude.
    a_den_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_error) |-> (o_res_den != '0 && !(o_less && o_equal)))
        else $error("bad denominator or inconsistent comparison flags");

endmodule

### sim/tb.sv
// Self-checking testbench for rational_arith_gcd_reduce_core: directed cases, then random
// fractions under four pacing phases. Depends on rtl/ratgcd_pkg.sv and the core's RTL.
`timescale 1ns / 100ps

module tb;
    import ratgcd_pkg::*;

    // Operand width under test. The prediction sign-extends from the same bit as the core.
    localparam int OPW = 32;
    // The run is cut off here whatever happens. A correct run needs a small fraction of it.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Random transactions per pacing phase.
    localparam int RAND_PER_PHASE = 155;
    // Transactions offered while the output side is held off.
    localparam int HOLD_BATCH = 12;
    // Length of the long output hold-off, in cycles.
    localparam int HOLD_CYCLES = 600;
    // Cycles allowed after the last result for anything stray to show up.
    localparam int DRAIN_CYCLES = 300;

    localparam logic signed [31:0] OP_MAX = 32'sd2147483647;

    // One row of the directed table. When has_ans is set the answer is typed in,
    // otherwise it comes from the prediction below.
    typedef struct {
        t_cmd               cmd;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
        bit                 has_ans;
        t_result            ans;
    } t_frac_case;

    localparam t_result NO_ANS = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_ADD;
    logic signed [IN_W-1:0] i_a_num = '0;
    logic signed [IN_W-1:0] i_a_den = '0;
    logic signed [IN_W-1:0] i_b_num = '0;
    logic signed [IN_W-1:0] i_b_den = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [MAG_W-1:0] o_res_num;
    logic signed [MAG_W-1:0] o_res_den;
    logic        o_less;
    logic        o_equal;
    logic        o_error;

    // Results the core still owes, oldest first.
    t_result     pending_results[$];
    t_frac_case  frac_cases[$];

    int          fail_count = 0;
    int          results_checked = 0;
    int          flagged_errors = 0;
    int          fractions_sent = 0;
    int          cycle_count = 0;

    // Pacing knobs, in percent, set by the main sequence per phase.
    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    // The main sequence bumps hold_requests; the output side serves each request once.
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    rational_arith_gcd_reduce_core #(
        .OPERAND_WIDTH(OPW)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_less    (o_less),
        .o_equal   (o_equal),
        .o_error   (o_error)
    );

    always #1 i_clk = ~i_clk;

    // Sign-extends an operand port from bit OPW-1, as the core does with its low bits.
    function automatic longint widen_operand(input logic [31:0] v);
        logic signed [31:0] s;
        s = v << (32 - OPW);
        s = s >>> (32 - OPW);
        return longint'(s);
    endfunction

    // Computes the reduced fraction and the comparison flags for one transaction.
    function automatic t_result predict_fraction(input t_cmd cmd,
                                                 input logic [31:0] a_n, a_d, b_n, b_d);
        longint     an, ad, bn, bd;
        longint     lhs, rhs, xn, xd, prod_den, t1, t2, sum, prod_num;
        logic [63:0] nmag, dmag, x, y, r;
        bit         nneg, dneg;
        t_result    res;
        an = widen_operand(a_n);
        ad = widen_operand(a_d);
        bn = widen_operand(b_n);
        bd = widen_operand(b_d);
        res = '0;
        if (ad == 0 || bd == 0) begin
            // A zero denominator on input leaves the comparison flags clear.
            res.error = 1'b1;
        end else begin
            // Compare a and b through cross products; the inequality flips when exactly
            // one denominator is negative.
            lhs = an * bd;
            rhs = bn * ad;
            res.equal = (lhs == rhs);
            res.less = ((ad < 0) != (bd < 0)) ? (lhs > rhs) : (lhs < rhs);
            xn = (cmd == CMD_SUB) ? -bn : bn;
            xd = bd;
            if (cmd == CMD_DIV) begin
                xn = bd;
                xd = bn;
            end
            if (xd == 0) begin
                res.error = 1'b1;
            end else begin
                prod_den = ad * xd;
                dneg = prod_den < 0;
                dmag = dneg ? -prod_den : prod_den;
                if (cmd == CMD_ADD || cmd == CMD_SUB) begin
                    t1 = an * xd;
                    t2 = xn * ad;
                    sum = t1 + t2;
                    // The sign of the sum survives a wrap of the 64-bit addition.
                    if (t1 < 0 && t2 < 0)
                        nneg = 1'b1;
                    else if (t1 >= 0 && t2 >= 0)
                        nneg = 1'b0;
                    else
                        nneg = sum[63];
                    nmag = nneg ? -sum : sum;
                end else begin
                    prod_num = an * xn;
                    nneg = prod_num < 0;
                    nmag = nneg ? -prod_num : prod_num;
                end
                x = nmag;
                y = dmag;
                while (y != 0) begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                if (x == 0)
                    x = 1;
                nmag = nmag / x;
                dmag = dmag / x;
                if (nmag == 0)
                    nneg = 1'b0;
                if (!nneg && nmag > 64'h7fff_ffff_ffff_ffff)
                    nmag = 64'h7fff_ffff_ffff_ffff;
                res.num = nneg ? -nmag : nmag;
                res.den = dneg ? -dmag : dmag;
            end
        end
        if (res.error) begin
            res.num = 64'sd1;
            res.den = 64'sd1;
        end
        return res;
    endfunction

    function automatic void add_case(input t_cmd cmd,
                                     input logic signed [31:0] a_n, a_d, b_n, b_d,
                                     input bit has_ans, input t_result ans);
        t_frac_case c;
        c.cmd = cmd;
        c.a_num = a_n;
        c.a_den = a_d;
        c.b_num = b_n;
        c.b_den = b_d;
        c.has_ans = has_ans;
        c.ans = ans;
        frac_cases.insert(frac_cases.size(), c);
    endfunction

    // Random operand: zeros now and then, full-range words, small values that share
    // factors often, and values up to 15 shifted up so the GCD strips many factors of two.
    function automatic logic [31:0] rand_operand(input bit is_den);
        int unsigned pick;
        logic [31:0] v;
        pick = $urandom_range(99);
        if (pick < (is_den ? 3 : 6))
            v = '0;
        else if (pick < 40)
            v = $urandom;
        else if (pick < 75)
            v = 32'($urandom_range(1, 60));
        else
            v = 32'($urandom_range(1, 15)) << $urandom_range(0, 27);
        if (pick >= 40 && $urandom_range(1) == 1)
            v = -v;
        // The most negative word lies outside the operand range.
        if (v == 32'h8000_0000)
            v = 32'h8000_0001;
        return v;
    endfunction

    // Offers one transaction, after a random gap when the phase asks for one, and records
    // what the core must return once the core accepts it. Valid stays high on return so
    // that a following transaction can go out back to back.
    task automatic offer_fraction(input t_cmd cmd, input logic [31:0] a_n, a_d, b_n, b_d,
                                  input bit has_ans, input t_result ans);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_a_num <= a_n;
        i_a_den <= a_d;
        i_b_num <= b_n;
        i_b_den <= b_d;
        do @(posedge i_clk); while (!o_ready);
        pending_results.insert(pending_results.size(),
                               has_ans ? ans : predict_fraction(cmd, a_n, a_d, b_n, b_d));
        fractions_sent++;
    endtask

    task automatic offer_random_fraction;
        offer_fraction(t_cmd'($urandom_range(3)), rand_operand(1'b0), rand_operand(1'b1),
                       rand_operand(1'b0), rand_operand(1'b1), 1'b0, NO_ANS);
    endtask

    // Lowers valid and waits until every owed result has come back.
    task automatic drain_results;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Output side: random stalls per phase, and a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_ready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Every accepted result is checked against the oldest owed one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding: %0d/%0d",
                       o_res_num, o_res_den);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_error)
                    flagged_errors++;
                if (o_res_num !== want.num) begin
                    $error("res_num: expected %0d, got %0d", want.num, o_res_num);
                    fail_count++;
                end
                if (o_res_den !== want.den) begin
                    $error("res_den: expected %0d, got %0d", want.den, o_res_den);
                    fail_count++;
                end
                if (o_less !== want.less) begin
                    $error("less: expected %0d, got %0d", want.less, o_less);
                    fail_count++;
                end
                if (o_equal !== want.equal) begin
                    $error("equal: expected %0d, got %0d", want.equal, o_equal);
                    fail_count++;
                end
                if (o_error !== want.error) begin
                    $error("error: expected %0d, got %0d", want.error, o_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        // Plain arithmetic with answers that can be worked out by hand.
        add_case(CMD_ADD, 1, 2, 1, 3, 1'b1, '{64'sd5, 64'sd6, 1'b0, 1'b0, 1'b0});
        add_case(CMD_SUB, 1, 2, 1, 2, 1'b1, '{64'sd0, 64'sd1, 1'b0, 1'b1, 1'b0});
        add_case(CMD_MUL, 2, 3, 3, 4, 1'b1, '{64'sd1, 64'sd2, 1'b1, 1'b0, 1'b0});
        add_case(CMD_DIV, 1, 2, 1, 4, 1'b1, '{64'sd2, 64'sd1, 1'b0, 1'b0, 1'b0});
        add_case(CMD_MUL, 1, 1, 1, 1, 1'b1, '{64'sd1, 64'sd1, 1'b0, 1'b1, 1'b0});
        // Zero denominators on input: 1/1, error set, comparison flags clear.
        add_case(CMD_ADD, 3, 0, 1, 2, 1'b1, '{64'sd1, 64'sd1, 1'b0, 1'b0, 1'b1});
        add_case(CMD_MUL, 1, 2, 5, 0, 1'b1, '{64'sd1, 64'sd1, 1'b0, 1'b0, 1'b1});
        add_case(CMD_SUB, 0, 0, 0, 0, 1'b1, '{64'sd1, 64'sd1, 1'b0, 1'b0, 1'b1});
        // Division by a zero fraction: error set, but less and equal are still reported.
        add_case(CMD_DIV, 1, 2, 0, 3, 1'b1, '{64'sd1, 64'sd1, 1'b0, 1'b0, 1'b1});
        add_case(CMD_DIV, -1, 2, 0, 5, 1'b1, '{64'sd1, 64'sd1, 1'b1, 1'b0, 1'b1});
        // Zero numerator keeps the sign of the unreduced denominator.
        add_case(CMD_MUL, 0, -5, 3, 7, 1'b1, '{64'sd0, -64'sd1, 1'b1, 1'b0, 1'b0});
        add_case(CMD_ADD, 0, 3, 0, -4, 1'b0, NO_ANS);
        // Extremes of the operand range.
        add_case(CMD_MUL, OP_MAX, 1, OP_MAX, 1, 1'b1,
                 '{64'sd4611686014132420609, 64'sd1, 1'b0, 1'b1, 1'b0});
        add_case(CMD_ADD, OP_MAX, 1, OP_MAX, 1, 1'b0, NO_ANS);
        add_case(CMD_SUB, -OP_MAX, OP_MAX, OP_MAX, -OP_MAX, 1'b0, NO_ANS);
        add_case(CMD_MUL, -OP_MAX, 1, -OP_MAX, -1, 1'b0, NO_ANS);
        add_case(CMD_DIV, OP_MAX, -OP_MAX, -OP_MAX, OP_MAX, 1'b0, NO_ANS);
        add_case(CMD_DIV, OP_MAX, OP_MAX, OP_MAX, OP_MAX, 1'b0, NO_ANS);
        add_case(CMD_ADD, 1, OP_MAX, 1, OP_MAX - 1, 1'b0, NO_ANS);
        // Mixed signs, equal values written differently, and long runs of twos.
        add_case(CMD_SUB, 1, -2, -1, 2, 1'b0, NO_ANS);
        add_case(CMD_ADD, -7, -14, 3, 6, 1'b0, NO_ANS);
        add_case(CMD_DIV, 32'sd1073741824, 3, 32'sd536870912, -9, 1'b0, NO_ANS);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (frac_cases[k])
            offer_fraction(frac_cases[k].cmd, frac_cases[k].a_num, frac_cases[k].a_den,
                           frac_cases[k].b_num, frac_cases[k].b_den,
                           frac_cases[k].has_ans, frac_cases[k].ans);
        drain_results();

        // Four pacing phases: none, sender mostly idle, receiver mostly stalled, and both
        // at a light rate. The first one opens with a long output hold-off while the
        // sender keeps offering, so the core fills up and drops its ready.
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = (phase == 1) ? 80 : (phase == 3) ? 16 : 0;
            stall_pct = (phase == 2) ? 80 : (phase == 3) ? 16 : 0;
            if (phase == 0) begin
                hold_requests++;
                repeat (HOLD_BATCH) offer_random_fraction();
            end
            repeat (RAND_PER_PHASE) offer_random_fraction();
            // The sender pauses here until everything owed has come back.
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d fractions sent, %0d results checked, %0d of them flagged as errors,",
                 fractions_sent, results_checked, flagged_errors);
        $display("tb: over four pacing phases and one long output hold-off, %0d cycles",
                 cycle_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/ratgcd_pkg.sv
rtl/ratgcd_useq.sv
rtl/ratgcd_dpath.sv
rtl/rational_arith_gcd_reduce_core.sv
sim/tb.sv
